>>> hdl/nnsa_pkg.sv
// Shared types and constants for the nearest-neighbor scale address block.
package nnsa_pkg;

    // Field and datapath widths
    localparam int DEST_W     = 10;
    localparam int SRC_W      = 12;
    localparam int IDX_W      = 24;
    localparam int ZOOM_W     = 22;
    localparam int PAN_W      = 32;
    localparam int DIM_W      = 13;
    localparam int Q_SHIFT    = 16;
    localparam int STEP_W     = 33;
    localparam int PROD_W     = STEP_W + DEST_W;
    localparam int POS_W      = PROD_W + 1;
    localparam int BPOS_W     = POS_W - Q_SHIFT;
    localparam int CNT_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Constants
    localparam logic [DIM_W-1:0]  MAX_IMAGE_DIM = 13'd4096;
    localparam logic [STEP_W-1:0] STEP_RESET    = 33'd65536;
    localparam logic [PAN_W-1:0]  PAN_BIAS      = 32'h8000_0000;
    localparam logic [BPOS_W-1:0] HALF_BIAS     = 28'd32768;
    localparam logic [CNT_W-1:0]  DIV_LAST_BIT  = 6'd32;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ZOOM   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_X  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PAN_Y  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd4;

    typedef struct packed {
        logic [DEST_W-1:0] dest_x;
        logic [DEST_W-1:0] dest_y;
    } in_beat_t;

    typedef struct packed {
        logic              inside_res;
        logic [SRC_W-1:0]  src_x;
        logic [SRC_W-1:0]  src_y;
        logic [IDX_W-1:0]  src_index;
    } res_beat_t;

    // Settings seen by the datapath
    typedef struct packed {
        logic [STEP_W-1:0]      step;
        logic                   zoom_zero;
        logic signed [PAN_W-1:0] pan_x;
        logic signed [PAN_W-1:0] pan_y;
        logic [DIM_W-1:0]       width;
        logic [DIM_W-1:0]       height;
    } cfg_t;

endpackage

>>> hdl/nnsa_step_div.sv
// Bit-serial restoring divider that forms the step floor(2^32 / zoom).
module nnsa_step_div
    import nnsa_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [nnsa_pkg::ZOOM_W-1:0] divisor,
    output logic                       busy,
    output logic [nnsa_pkg::STEP_W-1:0] quot
);

    logic [ZOOM_W-1:0] dvsr_reg, dvsr_next;
    logic [ZOOM_W-1:0] rem_reg, rem_next;
    logic [STEP_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [ZOOM_W:0]   trial;
    logic              fits;

    // One quotient bit per cycle; dividend is 2^32, so only the first bit is 1
    always_comb
    begin
        trial     = {rem_reg, (cnt_reg == DIV_LAST_BIT)};
        fits      = (trial >= {1'b0, dvsr_reg});
        dvsr_next = dvsr_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dvsr_next = divisor;
            rem_next  = '0;
            cnt_next  = DIV_LAST_BIT;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? ZOOM_W'(trial - {1'b0, dvsr_reg}) : trial[ZOOM_W-1:0];
            quot_next = {quot_reg[STEP_W-2:0], fits};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = (cnt_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            quot_reg <= STEP_RESET;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            quot_reg <= quot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvsr_reg <= dvsr_next;
        rem_reg  <= rem_next;
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule

>>> hdl/nnsa_cfg_regs.sv
// Configuration registers and step computation.
module nnsa_cfg_regs
    import nnsa_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0] cfg_data,
    output nnsa_pkg::cfg_t                 cfg,
    output logic                           busy
);

    logic                    zoom_zero_reg, zoom_zero_next;
    logic signed [PAN_W-1:0] pan_x_reg, pan_x_next;
    logic signed [PAN_W-1:0] pan_y_reg, pan_y_next;
    logic [DIM_W-1:0]        width_reg, width_next;
    logic [DIM_W-1:0]        height_reg, height_next;
    logic                    div_start;
    logic [STEP_W-1:0]       step;

    // Register write decode
    always_comb
    begin
        zoom_zero_next = zoom_zero_reg;
        pan_x_next     = pan_x_reg;
        pan_y_next     = pan_y_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        div_start      = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_ZOOM:
                begin
                    zoom_zero_next = (cfg_data[ZOOM_W-1:0] == '0);
                    div_start      = (cfg_data[ZOOM_W-1:0] != '0);
                end
                REG_PAN_X:  pan_x_next  = cfg_data;
                REG_PAN_Y:  pan_y_next  = cfg_data;
                REG_WIDTH:  width_next  = cfg_data[DIM_W-1:0];
                REG_HEIGHT: height_next = cfg_data[DIM_W-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zoom_zero_reg <= 1'b0;
            pan_x_reg     <= '0;
            pan_y_reg     <= '0;
            width_reg     <= DIM_W'(1);
            height_reg    <= DIM_W'(1);
        end
        else
        begin
            zoom_zero_reg <= zoom_zero_next;
            pan_x_reg     <= pan_x_next;
            pan_y_reg     <= pan_y_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
        end
    end

    nnsa_step_div u_step_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (div_start),
        .divisor (cfg_data[ZOOM_W-1:0]),
        .busy    (busy),
        .quot    (step)
    );

    // Oversized dimensions clamp to the largest supported image
    always_comb
    begin
        cfg.step      = step;
        cfg.zoom_zero = zoom_zero_reg;
        cfg.pan_x     = pan_x_reg;
        cfg.pan_y     = pan_y_reg;
        cfg.width     = (width_reg > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : width_reg;
        cfg.height    = (height_reg > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : height_reg;
    end

endmodule

>>> hdl/nnsa_pipe.sv
// Four-stage address datapath: multiply, position, bounds, index.
module nnsa_pipe
    import nnsa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  nnsa_pkg::cfg_t       cfg,
    input  logic                 hold,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  nnsa_pkg::in_beat_t   item_data,
    output logic                 res_valid,
    input  logic                 res_stall,
    output nnsa_pkg::res_beat_t  res_data
);

    logic                v1_reg, v2_reg, v3_reg, v4_reg;
    logic                rdy1, rdy2, rdy3, rdy4;
    logic [PROD_W-1:0]   s1_prod_x_reg, s1_prod_y_reg;
    logic [BPOS_W-1:0]   s2_bx_reg, s2_by_reg;
    logic                s3_inside_reg;
    logic [SRC_W-1:0]    s3_sx_reg, s3_sy_reg;
    res_beat_t           s4_res_reg, s4_res_next;
    logic [POS_W-1:0]    pos_x, pos_y;
    logic [BPOS_W-1:0]   off_x, off_y;
    logic                ok_x, ok_y;
    logic [IDX_W:0]      idx_full;

    // Each stage loads when empty or when the stage after it moves
    assign rdy4       = !v4_reg || !res_stall;
    assign rdy3       = !v3_reg || rdy4;
    assign rdy2       = !v2_reg || rdy3;
    assign rdy1       = !v1_reg || rdy2;
    assign item_stall = !rdy1 || hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy1) v1_reg <= item_valid && !hold;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Stage 1: step * dest per axis
    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_prod_x_reg <= PROD_W'(cfg.step) * PROD_W'(item_data.dest_x);
            s1_prod_y_reg <= PROD_W'(cfg.step) * PROD_W'(item_data.dest_y);
        end
    end

    // Stage 2: biased pan plus offset, floor to whole pixels
    always_comb
    begin
        pos_x = POS_W'(cfg.pan_x ^ PAN_BIAS) + POS_W'(s1_prod_x_reg);
        pos_y = POS_W'(cfg.pan_y ^ PAN_BIAS) + POS_W'(s1_prod_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            s2_bx_reg <= pos_x[POS_W-1:Q_SHIFT];
            s2_by_reg <= pos_y[POS_W-1:Q_SHIFT];
        end
    end

    // Stage 3: remove bias, bounds test against the image
    always_comb
    begin
        off_x = s2_bx_reg - HALF_BIAS;
        off_y = s2_by_reg - HALF_BIAS;
        ok_x  = (s2_bx_reg >= HALF_BIAS) && (off_x < BPOS_W'(cfg.width));
        ok_y  = (s2_by_reg >= HALF_BIAS) && (off_y < BPOS_W'(cfg.height));
    end

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            s3_inside_reg <= ok_x && ok_y && !cfg.zoom_zero;
            s3_sx_reg     <= (ok_x && ok_y && !cfg.zoom_zero) ? off_x[SRC_W-1:0] : '0;
            s3_sy_reg     <= (ok_x && ok_y && !cfg.zoom_zero) ? off_y[SRC_W-1:0] : '0;
        end
    end

    // Stage 4: linear index into the output register; zero coords give zero
    always_comb
    begin
        idx_full               = (IDX_W+1)'(s3_sy_reg) * (IDX_W+1)'(cfg.width)
                               + (IDX_W+1)'(s3_sx_reg);
        s4_res_next.inside_res = s3_inside_reg;
        s4_res_next.src_x      = s3_sx_reg;
        s4_res_next.src_y      = s3_sy_reg;
        s4_res_next.src_index  = idx_full[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            s4_res_reg <= s4_res_next;
        end
    end

    assign res_valid = v4_reg;
    assign res_data  = s4_res_reg;

endmodule

>>> hdl/nearest_neighbor_scale_address.sv
// Top level of the nearest-neighbor zoom and pan address generator.
// Maps each destination viewport beat (dest_x, dest_y) to the nearest source pixel and its
// linear index, taking one beat per clock unless the result side or the step divider stalls
// it; the pipeline stages are multiply, position add, bounds test, and index multiply-add. The
// per-pixel step floor(2^32 / zoom) comes from a one-bit-per-cycle divider: after a nonzero
// write to the zoom register item_stall stays high while the new step is
// formed. After reset the step for zoom 1.0 is already loaded and no wait applies.
module nearest_neighbor_scale_address
    import nnsa_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           item_valid,
    output logic                           item_stall,
    input  nnsa_pkg::in_beat_t             item_data,
    output logic                           res_valid,
    input  logic                           res_stall,
    output nnsa_pkg::res_beat_t            res_data,
    input  logic                           cfg_we,
    input  logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnsa_pkg::CFG_DATA_W-1:0] cfg_data
);

    cfg_t cfg;
    logic div_busy;

    nnsa_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg),
        .busy      (div_busy)
    );

    nnsa_pipe u_pipe (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .hold       (div_busy),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

endmodule

>>> hdl/nnsa_checker.sv
// Port-level checks for the scale address block, bound to the top level.
module nnsa_checker
    import nnsa_pkg::*;
(
    input logic                           clk,
    input logic                           rst_n,
    input logic                           item_valid,
    input logic                           item_stall,
    input logic                           res_valid,
    input logic                           res_stall,
    input nnsa_pkg::res_beat_t            res_data,
    input logic                           cfg_we,
    input logic [nnsa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [nnsa_pkg::CFG_DATA_W-1:0] cfg_data
);

    // A stalled result beat stays offered
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result beat dropped while stalled");

    // Skip beats carry all-zero coordinates and index
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.inside_res |->
            res_data.src_x == '0 && res_data.src_y == '0 && res_data.src_index == '0)
        else $error("skip beat with nonzero fields");

    // A nonzero zoom write starts the step divider, which blocks input
    a_zoom_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_ZOOM && cfg_data[ZOOM_W-1:0] != '0 |=> item_stall)
        else $error("input taken while step is being recomputed");

    // With the output side free, an accepted beat comes out once it has passed every pipeline stage
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall ##1 !res_stall ##1 !res_stall ##1 !res_stall
            |=> res_valid)
        else $error("result missing after pipeline latency");

endmodule

bind nearest_neighbor_scale_address nnsa_checker u_nnsa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_data   (res_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
);

>>> sim/nearest_neighbor_scale_address_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the nearest-neighbor zoom and pan address generator.
module nearest_neighbor_scale_address_tb;
    import nnsa_pkg::*;

    localparam int     LATENCY      = 4;
    localparam int     LONG_HOLD    = 150;
    localparam int     RAND_SETS    = 4;
    localparam int     SET_BEATS    = 28;
    localparam longint RUN_LIMIT_NS = 2_000_000;

    localparam logic [CFG_DATA_W-1:0] ZOOM_ONE  = 32'd65536;
    localparam logic [CFG_DATA_W-1:0] ZOOM_MAX  = 32'd2097152;
    localparam logic [CFG_DATA_W-1:0] ZOOM_NONE = 32'd0;
    localparam logic [CFG_DATA_W-1:0] PAN_MIN   = 32'h8000_0000;
    localparam logic [CFG_DATA_W-1:0] PAN_MAX   = 32'h7FFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] PAN_NEG1  = 32'hFFFF_FFFF;
    localparam logic [CFG_DATA_W-1:0] DIM_FULL  = 32'd4096;
    localparam logic [CFG_DATA_W-1:0] DIM_OVER  = 32'd8191;

    // Expected source addresses, predicted from the register copy at accept time
    class addr_scoreboard;
        logic [ZOOM_W-1:0] zoom;
        logic [PAN_W-1:0]  pan_x;
        logic [PAN_W-1:0]  pan_y;
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        res_beat_t         pending_addr[$];
        int                errors;

        function new();
            zoom   = ZOOM_W'(ZOOM_ONE);
            pan_x  = '0;
            pan_y  = '0;
            width  = DIM_W'(1);
            height = DIM_W'(1);
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_ZOOM:   zoom   = val[ZOOM_W-1:0];
                REG_PAN_X:  pan_x  = val[PAN_W-1:0];
                REG_PAN_Y:  pan_y  = val[PAN_W-1:0];
                REG_WIDTH:  width  = val[DIM_W-1:0];
                REG_HEIGHT: height = val[DIM_W-1:0];
                default:    ;
            endcase
        endfunction

        // Nearest source pixel for one destination coordinate
        function res_beat_t map_pixel(in_beat_t b);
            longint unsigned stepv, bx, by, sx, sy, w, h;
            res_beat_t r;
            r = '0;
            w = 64'((width > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : width);
            h = 64'((height > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : height);
            if (zoom == '0)
                return r;
            stepv = (64'd1 << 32) / zoom;
            // positions carry a 2^31 bias so the floor stays unsigned
            bx = ((pan_x ^ PAN_BIAS) + stepv * b.dest_x) >> Q_SHIFT;
            by = ((pan_y ^ PAN_BIAS) + stepv * b.dest_y) >> Q_SHIFT;
            if (bx < HALF_BIAS || by < HALF_BIAS)
                return r;
            sx = bx - HALF_BIAS;
            sy = by - HALF_BIAS;
            if (sx >= w || sy >= h)
                return r;
            r.inside_res = 1'b1;
            r.src_x      = sx[SRC_W-1:0];
            r.src_y      = sy[SRC_W-1:0];
            r.src_index  = IDX_W'(sy * w + sx);
            return r;
        endfunction

        function void note_beat(in_beat_t b);
            pending_addr.push_back(map_pixel(b));
        endfunction

        function void check_result(res_beat_t got);
            res_beat_t want;
            if (pending_addr.size() == 0)
            begin
                $display("%0t: result with none expected, actual %p", $time, got);
                errors++;
                return;
            end
            want = pending_addr.pop_front();
            if (got.inside_res !== want.inside_res)
            begin
                $display("%0t: inside_res expected %0d actual %0d",
                         $time, want.inside_res, got.inside_res);
                errors++;
            end
            if (got.src_x !== want.src_x)
            begin
                $display("%0t: src_x expected %0d actual %0d", $time, want.src_x, got.src_x);
                errors++;
            end
            if (got.src_y !== want.src_y)
            begin
                $display("%0t: src_y expected %0d actual %0d", $time, want.src_y, got.src_y);
                errors++;
            end
            if (got.src_index !== want.src_index)
            begin
                $display("%0t: src_index expected %0d actual %0d",
                         $time, want.src_index, got.src_index);
                errors++;
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  item_valid;
    logic                  item_stall;
    in_beat_t              item_data;
    logic                  res_valid;
    logic                  res_stall;
    res_beat_t             res_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    addr_scoreboard addr_sb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    nearest_neighbor_scale_address u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item_data  (item_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: random stall, or a long hold-off counted down here
    initial
    begin
        res_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_stall <= 1'b1;
                hold_cycles--;
            end
            else
                res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Result monitor
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && res_valid && !res_stall)
                addr_sb.check_result(res_data);
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

    // Offer one beat, with random idle cycles first; returns at the falling edge after accept
    task automatic send_item(input logic [DEST_W-1:0] x, input logic [DEST_W-1:0] y);
        in_beat_t b;
        b.dest_x = x;
        b.dest_y = y;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item_data  <= b;
        do
            @(posedge clk);
        while (item_stall);
        addr_sb.note_beat(b);
        @(negedge clk);
    endtask

    // Drop valid and let every outstanding result come back
    task automatic wait_drained();
        item_valid <= 1'b0;
        while (addr_sb.pending_addr.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        addr_sb.write_reg(idx, val);
        @(negedge clk);
    endtask

    task automatic set_view(input logic [CFG_DATA_W-1:0] z, input logic [CFG_DATA_W-1:0] px,
                            input logic [CFG_DATA_W-1:0] py, input logic [CFG_DATA_W-1:0] w,
                            input logic [CFG_DATA_W-1:0] h);
        wait_drained();
        write_cfg(REG_ZOOM, z);
        write_cfg(REG_PAN_X, px);
        write_cfg(REG_PAN_Y, py);
        write_cfg(REG_WIDTH, w);
        write_cfg(REG_HEIGHT, h);
        cfg_we <= 1'b0;
    endtask

    // Mode changes land on a rising edge so the receiver never races them
    task automatic set_mode(input int s_pct, input int r_pct, input int hold);
        @(posedge clk);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        hold_cycles    = hold;
        @(negedge clk);
    endtask

    // Mostly moderate zoom with pans that land on the image, sometimes anything at all
    task automatic random_view();
        logic [CFG_DATA_W-1:0] z, px, py, w, h;
        int unsigned wc, hc;
        case ($urandom_range(0, 9))
            0:       z = $urandom();
            1:       z = $urandom_range(0, 1) ? 32'd1 : ZOOM_MAX;
            2:       z = $urandom_range(0, 1) ? ZOOM_NONE : ZOOM_ONE;
            default: z = $urandom_range(16384, 262144);
        endcase
        case ($urandom_range(0, 9))
            0:       w = $urandom();
            1:       w = $urandom_range(1, 64);
            default: w = $urandom_range(1, 4096);
        endcase
        case ($urandom_range(0, 9))
            0:       h = $urandom();
            1:       h = $urandom_range(1, 64);
            default: h = $urandom_range(1, 4096);
        endcase
        wc = 32'((w[DIM_W-1:0] > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : w[DIM_W-1:0]);
        hc = 32'((h[DIM_W-1:0] > MAX_IMAGE_DIM) ? MAX_IMAGE_DIM : h[DIM_W-1:0]);
        px = ($urandom_range(0, 6) == 0) ? $urandom()
                                          : $urandom_range(0, wc * 65536 + (1 << 20)) - (1 << 20);
        py = ($urandom_range(0, 6) == 0) ? $urandom()
                                          : $urandom_range(0, hc * 65536 + (1 << 20)) - (1 << 20);
        set_view(z, px, py, w, h);
    endtask

    task automatic random_beat();
        logic [DEST_W-1:0] x, y;
        x = DEST_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 1023));
        y = DEST_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                : $urandom_range(0, 1023));
        send_item(x, y);
    endtask

    initial
    begin
        int s_pcts[4];
        int r_pcts[4];
        s_pcts = '{0, 72, 0, 9};
        r_pcts = '{0, 0, 72, 9};
        rst_n      = 1'b0;
        item_valid = 1'b0;
        item_data  = '0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset view: 1x1 image at zoom 1.0
        send_item(0, 0);
        send_item(1, 0);
        send_item(1023, 1023);

        // Full-size image, unit zoom, viewport corners
        set_view(ZOOM_ONE, 0, 0, DIM_FULL, DIM_FULL);
        send_item(0, 0);
        send_item(1023, 1023);
        send_item(1023, 0);
        send_item(0, 1023);

        // Zoom of 32.0 and the smallest nonzero zoom
        set_view(ZOOM_MAX, 0, 0, DIM_FULL, DIM_FULL);
        send_item(1023, 1023);
        send_item(1, 1);
        set_view(32'd1, 0, 0, DIM_FULL, DIM_FULL);
        send_item(0, 0);
        send_item(1, 0);
        send_item(0, 1);

        // Zoom zero skips everything; an all-ones write masks to the widest zoom field
        set_view(ZOOM_NONE, 0, 0, DIM_FULL, DIM_FULL);
        send_item(5, 5);
        set_view(PAN_NEG1, 0, 0, DIM_FULL, DIM_FULL);
        send_item(1023, 1023);

        // Negative pan floors below zero; oversized dimensions clamp
        set_view(ZOOM_ONE, PAN_NEG1, PAN_NEG1, DIM_OVER, DIM_OVER);
        send_item(0, 0);
        send_item(1, 1);
        send_item(1023, 1023);

        // Pan extremes
        set_view(ZOOM_ONE, PAN_MAX, PAN_MIN, DIM_FULL, DIM_FULL);
        send_item(0, 0);

        // Zero width, then zero height
        set_view(ZOOM_ONE, 0, 0, 0, DIM_FULL);
        send_item(0, 0);
        set_view(ZOOM_ONE, 0, 0, DIM_OVER, 0);
        send_item(3, 0);

        // Writes past the register list must change nothing
        set_view(ZOOM_ONE, 0, 0, DIM_FULL, DIM_FULL);
        @(negedge clk);
        for (int i = int'(REG_HEIGHT) + 1; i < 2 ** CFG_IDX_W; i++)
            write_cfg(CFG_IDX_W'(i), $urandom());
        cfg_we <= 1'b0;
        send_item(2, 7);

        // Random views under each idling mode; one long receiver hold-off fills the pipe
        for (int m = 0; m < 4; m++)
        begin
            for (int s = 0; s < RAND_SETS; s++)
            begin
                random_view();
                set_mode(s_pcts[m], r_pcts[m], (m == 0 && s == 1) ? LONG_HOLD : 0);
                repeat (SET_BEATS) random_beat();
            end
        end

        wait_drained();
        if (addr_sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
